// ===== design/cft_pkg.sv =====
// Package for the CSV field tokenizer: character codes, event kinds and the
// result entry type. No dependencies.
package cft_pkg;

  // Character width of the text stream
  localparam int unsigned CHAR_W = 8;

  // Characters with fixed meaning
  localparam logic [CHAR_W-1:0] QUOTE_CH = 8'h22;
  localparam logic [CHAR_W-1:0] LF_CH    = 8'h0A;
  localparam logic [CHAR_W-1:0] CR_CH    = 8'h0D;

  // Separator after reset: comma
  localparam logic [CHAR_W-1:0] SEP_RESET = 8'h2C;

  // Event kinds
  localparam logic [1:0] EV_CHAR      = 2'd0;
  localparam logic [1:0] EV_FIELD_END = 2'd1;
  localparam logic [1:0] EV_ROW_END   = 2'd2;

  // Result queue depth (holds two results of one item plus slack)
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One result entry
  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } result_t;

endpackage

// ===== design/csv_field_tokenizer.sv =====
// Streaming CSV/TSV tokenizer top level: input register, classification
// and state update logic, and a small result queue. Depends on cft_pkg.
//
// Timing: an accepted character waits in the input register until the result queue has
// room for two results; its results are then written into the queue and offered from it.
// Throughput: one character per cycle while each character yields at most one
// result and out_stall is low; a character that ends a text with a pending row can
// yield two results, which the result queue drains at one per cycle while out_stall is low.
// Reset (rst_n, synchronous): tokenizer flags cleared, separator set to comma,
// input register and result queue emptied.
module csv_field_tokenizer (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [cft_pkg::CHAR_W-1:0] in_char_code,
  input  logic                      in_text_end,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_event_kind,
  output logic [cft_pkg::CHAR_W-1:0] out_field_char,
  output logic                      out_run_last,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cft_pkg::CHAR_W-1:0] cfg_separator
);
  import cft_pkg::*;

  // Configuration register
  logic [CHAR_W-1:0] sep_r;

  // Input register
  logic              s1_vld_r, s1_vld_nxt;
  logic [CHAR_W-1:0] s1_ch_r;
  logic              s1_end_r;

  // Tokenizer flags
  logic in_quotes_r, in_quotes_nxt;
  logic pend_r, pend_nxt;
  logic saw_any_r, saw_any_nxt;
  logic field_ne_r, field_ne_nxt;
  logic row_ne_r, row_ne_nxt;

  // Result queue
  result_t           q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] q_wp_r, q_wp_nxt;
  logic [QPTR_W-1:0] q_rp_r, q_rp_nxt;
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;

  logic in_acc, s1_go, room, pop;
  logic do_outside;
  logic r0_vld, row_close;
  logic [CHAR_W-1:0] r0_ch;
  logic [1:0]        r0_kind;
  result_t           ent_a, ent_b;
  logic [1:0]        push_n;
  logic [QPTR_W-1:0] wp_plus1;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign room      = (q_cnt_r <= QCNT_W'(QDEPTH - 2));
  assign s1_go     = s1_vld_r && room;
  assign in_stall  = s1_vld_r && !room;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (q_cnt_r != '0);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  // Classification and flag update for the character in the input register
  always_comb begin
    in_quotes_nxt = in_quotes_r;
    pend_nxt      = pend_r;
    saw_any_nxt   = saw_any_r;
    field_ne_nxt  = field_ne_r;
    row_ne_nxt    = row_ne_r;
    r0_vld        = 1'b0;
    r0_kind       = EV_CHAR;
    r0_ch         = '0;
    do_outside    = 1'b0;
    row_close     = 1'b0;

    if (pend_r) begin
      pend_nxt = 1'b0;
      if (s1_ch_r == QUOTE_CH) begin
        // doubled quote: one literal quote
        r0_vld       = 1'b1;
        r0_ch        = QUOTE_CH;
        field_ne_nxt = 1'b1;
      end else begin
        in_quotes_nxt = 1'b0;
        do_outside    = 1'b1;
      end
    end else if (in_quotes_r) begin
      if (s1_ch_r == QUOTE_CH) begin
        if (s1_end_r) begin
          in_quotes_nxt = 1'b0;
        end else begin
          pend_nxt = 1'b1;
        end
      end else begin
        r0_vld       = 1'b1;
        r0_ch        = s1_ch_r;
        field_ne_nxt = 1'b1;
      end
    end else begin
      do_outside = 1'b1;
    end

    // Outside quotes: quote, separator, LF, CR, plain character in that order
    if (do_outside) begin
      if (s1_ch_r == QUOTE_CH) begin
        in_quotes_nxt = 1'b1;
        saw_any_nxt   = 1'b1;
      end else if (s1_ch_r == sep_r) begin
        r0_vld       = 1'b1;
        r0_kind      = EV_FIELD_END;
        field_ne_nxt = 1'b0;
        row_ne_nxt   = 1'b1;
        saw_any_nxt  = 1'b1;
      end else if (s1_ch_r == LF_CH) begin
        r0_vld       = 1'b1;
        r0_kind      = EV_ROW_END;
        field_ne_nxt = 1'b0;
        row_ne_nxt   = 1'b0;
        saw_any_nxt  = 1'b0;
      end else if (s1_ch_r == CR_CH) begin
        r0_vld = 1'b0;
      end else begin
        r0_vld       = 1'b1;
        r0_ch        = s1_ch_r;
        field_ne_nxt = 1'b1;
        saw_any_nxt  = 1'b1;
      end
    end

    // End of text: close a pending row, then clear everything
    if (s1_end_r) begin
      row_close     = saw_any_nxt || field_ne_nxt || row_ne_nxt;
      in_quotes_nxt = 1'b0;
      pend_nxt      = 1'b0;
      saw_any_nxt   = 1'b0;
      field_ne_nxt  = 1'b0;
      row_ne_nxt    = 1'b0;
    end
  end

  // Pack the results of this character into up to two queue entries
  always_comb begin
    ent_b.kind = EV_ROW_END;
    ent_b.ch   = '0;
    ent_b.last = 1'b1;
    if (r0_vld) begin
      ent_a.kind = r0_kind;
      ent_a.ch   = r0_ch;
      ent_a.last = !row_close;
    end else begin
      ent_a = ent_b;
    end
    push_n = s1_go ? (2'({1'b0, r0_vld}) + 2'({1'b0, row_close})) : 2'd0;
  end

  assign wp_plus1 = q_wp_r + QPTR_W'(1);

  always_comb begin
    q_wp_nxt  = q_wp_r + QPTR_W'(push_n);
    q_rp_nxt  = pop ? (q_rp_r + QPTR_W'(1)) : q_rp_r;
    q_cnt_nxt = q_cnt_r + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= SEP_RESET;
      s1_vld_r    <= 1'b0;
      in_quotes_r <= 1'b0;
      pend_r      <= 1'b0;
      saw_any_r   <= 1'b0;
      field_ne_r  <= 1'b0;
      row_ne_r    <= 1'b0;
      q_wp_r      <= '0;
      q_rp_r      <= '0;
      q_cnt_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sep_r <= cfg_separator;
      end
      s1_vld_r <= s1_vld_nxt;
      if (s1_go) begin
        in_quotes_r <= in_quotes_nxt;
        pend_r      <= pend_nxt;
        saw_any_r   <= saw_any_nxt;
        field_ne_r  <= field_ne_nxt;
        row_ne_r    <= row_ne_nxt;
      end
      q_wp_r  <= q_wp_nxt;
      q_rp_r  <= q_rp_nxt;
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // Payload registers: input stage and queue entries
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r  <= in_char_code;
      s1_end_r <= in_text_end;
    end
    if (push_n != 2'd0) begin
      q_mem_r[q_wp_r] <= ent_a;
    end
    if (push_n == 2'd2) begin
      q_mem_r[wp_plus1] <= ent_b;
    end
  end

  // Result port
  assign out_event_kind = q_mem_r[q_rp_r].kind;
  assign out_field_char = q_mem_r[q_rp_r].ch;
  assign out_run_last   = q_mem_r[q_rp_r].last;

`ifndef SYNTHESIS
  // Queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue count out of range");

  // A character only advances when the queue has room for two results
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> (q_cnt_r <= QCNT_W'(QDEPTH - 2)))
    else $error("character advanced without queue room");

  // A pending quote only exists inside quotes
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> in_quotes_r)
    else $error("pending quote outside quotes");

  // End of text leaves all flags cleared
  a_text_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_end_r) |=>
      !(in_quotes_r || pend_r || saw_any_r || field_ne_r || row_ne_r))
    else $error("flags not cleared after end of text");

  // Each character pushes at most two results, and pushes nothing when idle
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_go |=> (q_cnt_r <= $past(q_cnt_r)))
    else $error("result pushed without a character");
`endif

endmodule

// ===== tb/tb_csv_field_tokenizer.sv =====
// Self-checking testbench for csv_field_tokenizer: directed and random CSV/TSV text
// under several separators, checked against a built-in tokenizer model.
// Depends on cft_pkg and the csv_field_tokenizer RTL.
module tb_csv_field_tokenizer;
  import cft_pkg::*;

  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 40;
  localparam int PHASE_ITEMS    = 75;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_item_t;

  // Clock, reset and DUT ports
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic              in_text_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_event_kind;
  logic [CHAR_W-1:0] out_field_char;
  logic              out_run_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CHAR_W-1:0] cfg_separator = '0;

  // Stimulus and expectation stores
  text_item_t char_queue[$];
  text_item_t row_buf[$];
  text_item_t cur_item;
  result_t    expected_events[$];
  result_t    step_events[$];
  int         chars_queued = 0;

  // Tokenizer model state
  logic [CHAR_W-1:0] sep_cfg = SEP_RESET;
  logic              tok_in_quotes = 1'b0;
  logic              tok_quote_pending = 1'b0;
  logic              tok_saw_any = 1'b0;
  logic              tok_field_open = 1'b0;
  logic              tok_row_open = 1'b0;

  // Flow control
  logic in_fire = 1'b0;
  logic quiet = 1'b0;
  int   in_gap = 0;
  int   hold_cnt = 0;
  int   long_holds_wanted = 0;
  int   long_holds_done = 0;
  int   idle_cycles = 0;
  int   mismatch_cnt = 0;

  csv_field_tokenizer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_text_end    (in_text_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_field_char (out_field_char),
    .out_run_last   (out_run_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_separator  (cfg_separator)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------
  task automatic add_event(input logic [1:0] kind, input logic [CHAR_W-1:0] ch);
    result_t ev;
    ev.kind = kind;
    ev.ch   = (kind == EV_CHAR) ? ch : '0;
    ev.last = 1'b0;
    step_events.push_back(ev);
  endtask

  // Character seen outside quotes: quote wins over separator, separator over LF/CR
  task automatic handle_unquoted(input logic [CHAR_W-1:0] c);
    if (c == QUOTE_CH) begin
      tok_in_quotes = 1'b1;
      tok_saw_any   = 1'b1;
    end else if (c == sep_cfg) begin
      add_event(EV_FIELD_END, '0);
      tok_field_open = 1'b0;
      tok_row_open   = 1'b1;
      tok_saw_any    = 1'b1;
    end else if (c == LF_CH) begin
      add_event(EV_ROW_END, '0);
      tok_field_open = 1'b0;
      tok_row_open   = 1'b0;
      tok_saw_any    = 1'b0;
    end else if (c != CR_CH) begin
      add_event(EV_CHAR, c);
      tok_field_open = 1'b1;
      tok_saw_any    = 1'b1;
    end
  endtask

  // Update the model with one accepted character and queue its events
  task automatic tokenize_char(input logic [CHAR_W-1:0] c, input logic is_end);
    result_t ev;
    step_events.delete();
    if (tok_quote_pending) begin
      tok_quote_pending = 1'b0;
      if (c == QUOTE_CH) begin
        add_event(EV_CHAR, QUOTE_CH);
        tok_field_open = 1'b1;
      end else begin
        tok_in_quotes = 1'b0;
        handle_unquoted(c);
      end
    end else if (tok_in_quotes) begin
      if (c == QUOTE_CH) begin
        // no lookahead on the final character: the quote just closes
        if (is_end) tok_in_quotes = 1'b0;
        else tok_quote_pending = 1'b1;
      end else begin
        add_event(EV_CHAR, c);
        tok_field_open = 1'b1;
      end
    end else begin
      handle_unquoted(c);
    end
    if (is_end) begin
      if (tok_saw_any || tok_field_open || tok_row_open) add_event(EV_ROW_END, '0);
      tok_in_quotes     = 1'b0;
      tok_quote_pending = 1'b0;
      tok_saw_any       = 1'b0;
      tok_field_open    = 1'b0;
      tok_row_open      = 1'b0;
    end
    if (step_events.size() != 0) begin
      ev = step_events.pop_back();
      ev.last = 1'b1;
      step_events.push_back(ev);
    end
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Input acceptance: feed the model at the edge where a character is taken
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) tokenize_char(in_char_code, in_text_end);
  end

  // Result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected event, kind", int'(out_event_kind), 0);
      end else begin
        want = expected_events.pop_front();
        if (out_event_kind != want.kind)
          report_mismatch("event_kind", int'(out_event_kind), int'(want.kind));
        if (out_field_char != want.ch)
          report_mismatch("field_char", int'(out_field_char), int'(want.ch));
        if (out_run_last != want.last)
          report_mismatch("run_last", int'(out_run_last), int'(want.last));
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver
  // ---------------------------------------------------------------------------
  // Sender: presents the next character once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap != 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (char_queue.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
        in_gap   <= $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else if (char_queue.size() != 0) begin
        cur_item     = char_queue.pop_front();
        in_char_code <= cur_item.ch;
        in_text_end  <= cur_item.last;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: short random stall bursts plus requested long hold-offs
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (long_holds_done != long_holds_wanted) begin
      long_holds_done <= long_holds_done + 1;
      hold_cnt        <= LONG_HOLD - 1;
      out_stall       <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      hold_cnt  <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_char(input logic [CHAR_W-1:0] c, input logic is_end);
    text_item_t it;
    it.ch   = c;
    it.last = is_end;
    row_buf.push_back(it);
  endtask

  task automatic flush_row();
    foreach (row_buf[i]) char_queue.push_back(row_buf[i]);
    chars_queued += row_buf.size();
    row_buf.delete();
  endtask

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255));
    while (c == QUOTE_CH || c == sep_cfg || c == LF_CH || c == CR_CH);
    return c;
  endfunction

  // Random CSV rows with random content, plus some raw noise
  task automatic gen_text(input int n_chars);
    int          start;
    int          n_fields;
    int          len;
    text_item_t  it;
    start = chars_queued;
    while (chars_queued - start < n_chars) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6))
          push_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else begin
        n_fields = $urandom_range(1, 4);
        for (int f = 0; f < n_fields; f++) begin
          len = $urandom_range(0, 4);
          if ($urandom_range(0, 2) == 0) begin
            // quoted field: separators, newlines and doubled quotes inside
            push_char(QUOTE_CH, 1'b0);
            for (int k = 0; k < len; k++) begin
              case ($urandom_range(0, 5))
                0: begin
                  push_char(QUOTE_CH, 1'b0);
                  push_char(QUOTE_CH, 1'b0);
                end
                1: push_char(sep_cfg, 1'b0);
                2: push_char(LF_CH, 1'b0);
                default: push_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
              endcase
            end
            push_char(QUOTE_CH, 1'b0);
          end else begin
            for (int k = 0; k < len; k++) push_char(plain_char(), 1'b0);
          end
          if (f != n_fields - 1) push_char(sep_cfg, 1'b0);
        end
        // row terminator, or end of text on the row's last character
        case ($urandom_range(0, 5))
          0: begin
            if (row_buf.size() == 0) begin
              push_char(LF_CH, 1'b1);
            end else begin
              it = row_buf.pop_back();
              it.last = 1'b1;
              row_buf.push_back(it);
            end
          end
          1: begin
            push_char(CR_CH, 1'b0);
            push_char(LF_CH, 1'b0);
          end
          default: push_char(LF_CH, $urandom_range(0, 7) == 0);
        endcase
      end
      flush_row();
    end
  endtask

  // Wait until every character is taken and every event has come out
  task automatic wait_drained();
    while (char_queue.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_separator(input logic [CHAR_W-1:0] v);
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_separator <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sep_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CHAR_W-1:0] seps[8];
    seps = '{8'h09, 8'h3B, 8'h00, 8'hFF, QUOTE_CH, LF_CH, CR_CH, SEP_RESET};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed text under the reset separator (comma)
    push_char(8'h61, 1'b0);     // plain char
    push_char(8'h2C, 1'b0);     // separator
    push_char(8'h00, 1'b0);     // lowest code
    push_char(8'hFF, 1'b0);     // highest code
    push_char(CR_CH, 1'b0);     // dropped
    push_char(LF_CH, 1'b0);     // end of row
    push_char(QUOTE_CH, 1'b0);  // open quotes, no event
    push_char(8'h2C, 1'b0);     // separator inside quotes is text
    push_char(LF_CH, 1'b0);     // newline inside quotes is text
    push_char(QUOTE_CH, 1'b0);  // pending quote
    push_char(QUOTE_CH, 1'b0);  // doubled quote gives one literal quote
    push_char(QUOTE_CH, 1'b0);  // pending quote
    push_char(8'h78, 1'b0);     // closes quotes, then plain char
    push_char(8'h2C, 1'b0);
    push_char(QUOTE_CH, 1'b0);
    push_char(8'h79, 1'b0);
    push_char(QUOTE_CH, 1'b1);  // quote on the final character closes quotes
    push_char(QUOTE_CH, 1'b0);
    push_char(8'h7A, 1'b1);     // unterminated quoted text at the end
    push_char(LF_CH, 1'b1);     // end of text right after a row end
    push_char(CR_CH, 1'b1);     // end of text with nothing seen
    push_char(8'h71, 1'b0);
    push_char(QUOTE_CH, 1'b0);  // opening quote mid-field
    push_char(QUOTE_CH, 1'b0);  // pending
    push_char(8'h2C, 1'b0);     // closes quotes and ends the field
    push_char(8'hFF, 1'b1);
    flush_row();
    wait_drained();

    // Random phases, one per separator; the first one also holds off the receiver
    foreach (seps[p]) begin
      write_separator(seps[p]);
      if (p == 0) long_holds_wanted++;
      if (p == 7) quiet = 1'b1;
      gen_text(PHASE_ITEMS);
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cft_pkg.sv
design/csv_field_tokenizer.sv
tb/tb_csv_field_tokenizer.sv
